// ===== rtl/tfp_pkg.sv =====
// Package for the track filter predictor: field widths, request and
// register codes, shared types. No dependencies.
package tfp_pkg;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SUM_W      = COORD_W + 3;
   localparam int GAIN_W     = 17;
   localparam int RAD_W      = 23;
   localparam int MISS_W     = 8;
   localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
   localparam int DIV_W      = 25;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 23;

   localparam logic [GAIN_W-1:0] GAIN_ONE    = 17'h10000;
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 17'h08000;
   localparam logic [RAD_W-1:0]  RAD_RESET   = 23'd2560;
   localparam logic [MISS_W-1:0] MISS_MAX    = 8'hFF;

   // request kinds
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_GAIN  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_RADIUS = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

endpackage

// ===== rtl/tfp_if.sv =====
// Channel interfaces of the track filter predictor: request, response and
// register write. Depends on tfp_pkg.
interface tfp_req_if import tfp_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      req_type;
   logic      meas_valid;
   coord_type meas_x;
   coord_type meas_y;

   modport source(output valid, req_type, meas_valid, meas_x, meas_y, input ready);
   modport sink(input valid, req_type, meas_valid, meas_x, meas_y, output ready);
endinterface

interface tfp_rsp_if import tfp_pkg::*; ();
   logic              valid;
   logic              ready;
   coord_type         track_x;
   coord_type         track_y;
   coord_type         pred_x;
   coord_type         pred_y;
   logic              in_gate;
   logic [MISS_W-1:0] miss_count;

   modport source(output valid, track_x, track_y, pred_x, pred_y, in_gate, miss_count,
                  input ready);
   modport sink(input valid, track_x, track_y, pred_x, pred_y, in_gate, miss_count,
                output ready);
endinterface

interface tfp_csr_if import tfp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/tfp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tfp_pkg for the dividend width.
module tfp_div import tfp_pkg::*; #(
   parameter int DEN_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // shift in the next dividend bit and try one subtraction
   always_comb begin
      trial   = {rem_ff, num_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// ===== rtl/track_filter_predictor.sv =====
// Track filter predictor: gates, blends or extrapolates one sweep report per request.
// Start request: evaluate, push the measurement, respond; report without a track: evaluate, respond.
// Report on a track: evaluate, push, read back, run the one-bit-per-cycle dividers, respond.
// One request in flight; the next is taken the cycle after the response loads, even if it waits.
// Synchronous active-high reset clears control, counters, prediction and registers;
// the history memory is not cleared. Depends on tfp_pkg, tfp_if and tfp_div.
module track_filter_predictor import tfp_pkg::*; #(
   parameter int WINDOW = 8
) (
   input  logic       clock,
   input  logic       reset,
   tfp_req_if.sink    req_bus,
   tfp_rsp_if.source  rsp_bus,
   tfp_csr_if.sink    csr_bus
);

   localparam int DEPTH = WINDOW + 1;
   localparam int SW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int WW    = SW;
   localparam int MW    = 2 * COORD_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_PUSH = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(8388608);

   logic [2:0]          state_ff, state_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [RAD_W-1:0]    radius_ff, radius_in;

   // latched request
   logic                type_ff, mvalid_ff;
   coord_type           mx_ff, my_ff;

   // track state
   coord_type           last_x_ff, last_x_in, last_y_ff, last_y_in;
   coord_type           pred_x_ff, pred_x_in, pred_y_ff, pred_y_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [MISS_W-1:0]   miss_ff, miss_in;

   // per-request work registers
   coord_type           new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic                blend_ff, blend_in;
   logic                gate_ff, gate_in;
   logic                zero_ff, zero_in;
   logic [WW-1:0]       w_ff, w_in;
   logic                neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   coord_type           o_track_x_ff, o_track_x_in, o_track_y_ff, o_track_y_in;
   coord_type           o_pred_x_ff, o_pred_x_in, o_pred_y_ff, o_pred_y_in;
   logic                o_gate_ff, o_gate_in;
   logic [MISS_W-1:0]   o_miss_ff, o_miss_in;

   // history memory
   logic [MW-1:0]       hist_mem [DEPTH];
   logic [MW-1:0]       rd_data_ff;
   logic                mem_we;
   logic [SW-1:0]       rd_addr;
   logic [MW-1:0]       wr_data;

   // combinational helpers
   logic                req_fire, rsp_fire, out_free;
   logic [GAIN_W-1:0]   gain_eff;
   diff_type            ax, ay, bx, by, dx, dy;
   logic [DIFF_W-1:0]   ax_mag, ay_mag, dx_mag, dy_mag;
   logic signed [PROD_W-1:0] rnd_x, rnd_y;
   logic signed [SUM_W-1:0]  blend_x, blend_y, sum_x, sum_y, step_x, step_y;
   coord_type           push_x, push_y, old_x, old_y;
   logic [CW-1:0]       count_next;
   logic [WW-1:0]       w_next;
   logic [SW:0]         addr_wide;
   logic [DIV_W-1:0]    dvd_x, dvd_y, quo_x, quo_y;
   logic                div_start, div_busy_x, div_busy_y, div_done_x, div_done_y;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign gain_eff = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   // gate distances against the last track point
   assign ax     = diff_type'(mx_ff) - diff_type'(last_x_ff);
   assign ay     = diff_type'(my_ff) - diff_type'(last_y_ff);
   assign ax_mag = ax[DIFF_W-1] ? DIFF_W'(-ax) : DIFF_W'(ax);
   assign ay_mag = ay[DIFF_W-1] ? DIFF_W'(-ay) : DIFF_W'(ay);

   // blend operands: measurement minus prediction
   assign bx = diff_type'(mx_ff) - diff_type'(pred_x_ff);
   assign by = diff_type'(my_ff) - diff_type'(pred_y_ff);

   // round half up and add back the prediction
   assign rnd_x   = (prod_x_ff + PROD_W'(32768)) >>> 16;
   assign rnd_y   = (prod_y_ff + PROD_W'(32768)) >>> 16;
   assign blend_x = SUM_W'(pred_x_ff) + SUM_W'(rnd_x);
   assign blend_y = SUM_W'(pred_y_ff) + SUM_W'(rnd_y);
   assign push_x  = blend_ff ? blend_x[COORD_W-1:0] : new_x_ff;
   assign push_y  = blend_ff ? blend_y[COORD_W-1:0] : new_y_ff;

   // ring bookkeeping for the point being pushed
   assign count_next = (count_ff < CW'(DEPTH)) ? count_ff + 1'b1 : count_ff;
   assign w_next     = WW'(count_next - 1'b1);
   assign addr_wide  = ({1'b0, slot_ff} >= (SW + 1)'(w_next))
                       ? {1'b0, slot_ff} - (SW + 1)'(w_next)
                       : {1'b0, slot_ff} + (SW + 1)'(DEPTH) - (SW + 1)'(w_next);
   assign rd_addr    = addr_wide[SW-1:0];
   assign wr_data    = {push_y, push_x};
   assign mem_we     = (state_ff == S_PUSH);

   // velocity numerators from the old point
   assign old_x  = rd_data_ff[COORD_W-1:0];
   assign old_y  = rd_data_ff[MW-1:COORD_W];
   assign dx     = diff_type'(last_x_ff) - diff_type'(old_x);
   assign dy     = diff_type'(last_y_ff) - diff_type'(old_y);
   assign dx_mag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign dy_mag = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   assign dvd_x  = DIV_W'(dx_mag) + DIV_W'(w_ff >> 1);
   assign dvd_y  = DIV_W'(dy_mag) + DIV_W'(w_ff >> 1);
   assign div_start = (state_ff == S_READ);

   // extrapolated point before saturation
   assign step_x = neg_x_ff ? -SUM_W'(quo_x) : SUM_W'(quo_x);
   assign step_y = neg_y_ff ? -SUM_W'(quo_y) : SUM_W'(quo_y);
   assign sum_x  = SUM_W'(last_x_ff) + step_x;
   assign sum_y  = SUM_W'(last_y_ff) + step_y;

   tfp_div #(.DEN_W(WW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_x),
      .divisor  (w_ff),
      .busy     (div_busy_x),
      .done     (div_done_x),
      .quotient (quo_x)
   );

   tfp_div #(.DEN_W(WW)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_y),
      .divisor  (w_ff),
      .busy     (div_busy_y),
      .done     (div_done_y),
      .quotient (quo_y)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      radius_in    = radius_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      pred_x_in    = pred_x_ff;
      pred_y_in    = pred_y_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      miss_in      = miss_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      blend_in     = blend_ff;
      gate_in      = gate_ff;
      zero_in      = zero_ff;
      w_in         = w_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      o_track_x_in = o_track_x_ff;
      o_track_y_in = o_track_y_ff;
      o_pred_x_in  = o_pred_x_ff;
      o_pred_y_in  = o_pred_y_ff;
      o_gate_in    = o_gate_ff;
      o_miss_in    = o_miss_ff;

      // register writes
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_BLEND_GAIN:  gain_in   = csr_bus.data[GAIN_W-1:0];
            CSR_GATE_RADIUS: radius_in = csr_bus.data[RAD_W-1:0];
            default:         gain_in   = gain_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_EVAL;
         end
         S_EVAL: begin
            zero_in  = 1'b0;
            blend_in = 1'b0;
            new_x_in = mx_ff;
            new_y_in = my_ff;
            if (type_ff == REQ_START) begin
               // open a new track at the measurement
               gate_in  = 1'b0;
               miss_in  = '0;
               slot_in  = '0;
               count_in = '0;
               state_in = S_PUSH;
            end else if (count_ff == '0) begin
               // no track: answer with zeros
               zero_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               gate_in = mvalid_ff && (ax_mag < DIFF_W'(radius_ff))
                         && (ay_mag < DIFF_W'(radius_ff));
               if (mvalid_ff) begin
                  miss_in   = '0;
                  blend_in  = (count_ff != CW'(1));
                  prod_x_in = $signed({1'b0, gain_eff}) * bx;
                  prod_y_in = $signed({1'b0, gain_eff}) * by;
               end else begin
                  new_x_in = pred_x_ff;
                  new_y_in = pred_y_ff;
                  if (miss_ff != MISS_MAX) miss_in = miss_ff + 1'b1;
               end
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // store the new point and fetch the one w back
            last_x_in = push_x;
            last_y_in = push_y;
            slot_in   = (slot_ff == SW'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            count_in  = count_next;
            w_in      = w_next;
            if (w_next == '0) begin
               pred_x_in = push_x;
               pred_y_in = push_y;
               state_in  = S_OUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            neg_x_in = dx[DIFF_W-1];
            neg_y_in = dy[DIFF_W-1];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done_x && div_done_y) begin
               pred_x_in = (sum_x > SAT_HI) ? SAT_HI[COORD_W-1:0] :
                           (sum_x < SAT_LO) ? SAT_LO[COORD_W-1:0] : sum_x[COORD_W-1:0];
               pred_y_in = (sum_y > SAT_HI) ? SAT_HI[COORD_W-1:0] :
                           (sum_y < SAT_LO) ? SAT_LO[COORD_W-1:0] : sum_y[COORD_W-1:0];
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // hand the response over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_track_x_in = zero_ff ? '0 : last_x_ff;
               o_track_y_in = zero_ff ? '0 : last_y_ff;
               o_pred_x_in  = zero_ff ? '0 : pred_x_ff;
               o_pred_y_in  = zero_ff ? '0 : pred_y_ff;
               o_gate_in    = zero_ff ? 1'b0 : gate_ff;
               o_miss_in    = zero_ff ? '0 : miss_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= GAIN_RESET;
         radius_ff    <= RAD_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         pred_x_ff    <= '0;
         pred_y_ff    <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         miss_ff      <= '0;
         zero_ff      <= 1'b0;
         blend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         radius_ff    <= radius_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         pred_x_ff    <= pred_x_in;
         pred_y_ff    <= pred_y_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         miss_ff      <= miss_in;
         zero_ff      <= zero_in;
         blend_ff     <= blend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // latch the request payload
      if (req_fire) begin
         type_ff   <= req_bus.req_type;
         mvalid_ff <= req_bus.meas_valid;
         mx_ff     <= req_bus.meas_x;
         my_ff     <= req_bus.meas_y;
      end
      new_x_ff     <= new_x_in;
      new_y_ff     <= new_y_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      gate_ff      <= gate_in;
      w_ff         <= w_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      o_track_x_ff <= o_track_x_in;
      o_track_y_ff <= o_track_y_in;
      o_pred_x_ff  <= o_pred_x_in;
      o_pred_y_ff  <= o_pred_y_in;
      o_gate_ff    <= o_gate_in;
      o_miss_ff    <= o_miss_in;
   end

   // history ring: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[slot_ff] <= wr_data;
      rd_data_ff <= hist_mem[rd_addr];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.track_x    = o_track_x_ff;
   assign rsp_bus.track_y    = o_track_y_ff;
   assign rsp_bus.pred_x     = o_pred_x_ff;
   assign rsp_bus.pred_y     = o_pred_y_ff;
   assign rsp_bus.in_gate    = o_gate_ff;
   assign rsp_bus.miss_count = o_miss_ff;

   // point count never passes the ring depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("point count beyond ring depth");

   // write slot stays inside the ring
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < (SW + 1)'(DEPTH))
      else $error("write slot outside ring");

   // an accepted request moves straight to evaluation
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EVAL)
      else $error("accepted request not evaluated");

   // the dividers are never restarted mid-division
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy_x && !div_busy_y)
      else $error("divider started while busy");

endmodule

// ===== tb/sv/track_filter_predictor_tb.sv =====
// Self-checking bench for the track filter predictor: drives sweep requests,
// predicts each response with its own alpha-filter model and compares them.
// Depends on tfp_pkg, tfp_if and the track_filter_predictor RTL.
module track_filter_predictor_tb import tfp_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW       = 8;
   localparam int RING_DEPTH   = WINDOW + 1;
   localparam int LIMIT_CYCLES = 500000;
   localparam int TAIL_CYCLES  = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 400;

   localparam longint TOP_L    = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint BOTTOM_L = -(longint'(1) << (COORD_W - 1));
   localparam coord_type COORD_TOP    = coord_type'(TOP_L);
   localparam coord_type COORD_BOTTOM = coord_type'(BOTTOM_L);

   typedef struct packed {
      coord_type         track_x;
      coord_type         track_y;
      coord_type         pred_x;
      coord_type         pred_y;
      logic              in_gate;
      logic [MISS_W-1:0] miss_count;
   } sweep_result_type;

   logic clock;
   logic reset;

   tfp_req_if req_bus();
   tfp_rsp_if rsp_bus();
   tfp_csr_if csr_bus();

   track_filter_predictor #(.WINDOW(WINDOW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // filter state as the bench sees it
   coord_type         ring_x [RING_DEPTH];
   coord_type         ring_y [RING_DEPTH];
   int unsigned       ring_head;
   int unsigned       ring_fill;
   int unsigned       coast_run;
   coord_type         next_x;
   coord_type         next_y;
   logic [GAIN_W-1:0] gain_q16;
   logic [RAD_W-1:0]  strobe_half;

   sweep_result_type pending_tracks[$];
   sweep_result_type seen_result;
   sweep_result_type want_result;

   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int cycle_count;
   int items_sent;
   int results_checked;
   int mismatches;
   int gate_hits;
   int rail_hits;
   int coast_peak;
   int register_loads;

   // ---------------------------------------------------------------- predictor

   function automatic coord_type clamp_coord(longint v);
      if (v > TOP_L) return COORD_TOP;
      if (v < BOTTOM_L) return COORD_BOTTOM;
      return coord_type'(v);
   endfunction

   // weighted mix of measurement and prediction, round half up
   function automatic coord_type blend_axis(coord_type meas, coord_type pred);
      longint k;
      longint acc;
      k = (gain_q16 > GAIN_ONE) ? 65536 : longint'(gain_q16);
      acc = k * longint'(meas) + (65536 - k) * longint'(pred) + 32768;
      return clamp_coord(acc >>> 16);
   endfunction

   // divide rounding to nearest, ties away from zero
   function automatic longint step_toward(longint d, longint w);
      longint mag;
      longint q;
      mag = (d < 0) ? -d : d;
      q = (mag + w / 2) / w;
      return (d < 0) ? -q : q;
   endfunction

   function automatic int unsigned newest_slot();
      return (ring_head + RING_DEPTH - 1) % RING_DEPTH;
   endfunction

   // store a track point and extrapolate the next one over the window
   function automatic void append_point(coord_type x, coord_type y);
      int unsigned last;
      int unsigned back;
      int unsigned span;
      ring_x[ring_head] = x;
      ring_y[ring_head] = y;
      ring_head = (ring_head + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      last = newest_slot();
      span = ring_fill - 1;
      if (span > WINDOW) span = WINDOW;
      if (span == 0) begin
         next_x = ring_x[last];
         next_y = ring_y[last];
      end else begin
         back = (ring_head + RING_DEPTH - 1 - span) % RING_DEPTH;
         next_x = clamp_coord(longint'(ring_x[last]) +
                  step_toward(longint'(ring_x[last]) - longint'(ring_x[back]), span));
         next_y = clamp_coord(longint'(ring_y[last]) +
                  step_toward(longint'(ring_y[last]) - longint'(ring_y[back]), span));
      end
   endfunction

   function automatic sweep_result_type filter_sweep(logic kind, logic seen,
                                                     coord_type mx, coord_type my);
      sweep_result_type r;
      int unsigned last;
      longint dx;
      longint dy;
      logic hit;
      coord_type nx;
      coord_type ny;
      r = '0;
      hit = 1'b0;
      if (kind == REQ_START) begin
         ring_head = 0;
         ring_fill = 0;
         coast_run = 0;
         append_point(mx, my);
      end else if (ring_fill == 0) begin
         // no track yet: drop the report, answer with zeros
         return r;
      end else begin
         last = newest_slot();
         dx = longint'(mx) - longint'(ring_x[last]);
         dy = longint'(my) - longint'(ring_y[last]);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         hit = seen && (dx < longint'(strobe_half)) && (dy < longint'(strobe_half));
         if (seen) begin
            if (ring_fill == 1) begin
               nx = mx;
               ny = my;
            end else begin
               nx = blend_axis(mx, next_x);
               ny = blend_axis(my, next_y);
            end
            coast_run = 0;
         end else begin
            nx = next_x;
            ny = next_y;
            if (coast_run < MISS_MAX) coast_run++;
         end
         append_point(nx, ny);
      end
      last = newest_slot();
      r.track_x    = ring_x[last];
      r.track_y    = ring_y[last];
      r.pred_x     = next_x;
      r.pred_y     = next_y;
      r.in_gate    = hit;
      r.miss_count = coast_run[MISS_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- value pickers

   function automatic coord_type any_coord();
      return coord_type'($urandom());
   endfunction

   function automatic coord_type rail_coord();
      case ($urandom_range(3))
         0: return COORD_TOP;
         1: return COORD_BOTTOM;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // measurement scattered around a point, wide enough to land on both sides of the gate up to a strobe of 10000
   function automatic coord_type near_coord(coord_type center);
      int lim;
      longint jitter;
      lim = (strobe_half > 10000) ? 20000 : 2 * int'(strobe_half) + 8;
      jitter = longint'($urandom_range(2 * lim)) - lim;
      return clamp_coord(longint'(center) + jitter);
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one request, hold valid across back-to-back requests
   task automatic send_sweep(logic kind, logic seen, coord_type mx, coord_type my);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.meas_valid <= seen;
      req_bus.meas_x     <= mx;
      req_bus.meas_y     <= my;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_tracks.push_back(filter_sweep(kind, seen, mx, my));
      items_sent++;
   endtask

   // drop valid and wait until the block has drained
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_tracks.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // write both registers back to back
   task automatic load_registers(logic [CSR_DATA_W-1:0] gain_word,
                                 logic [CSR_DATA_W-1:0] radius_word);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_BLEND_GAIN;
      csr_bus.data  <= gain_word;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      gain_q16 = gain_word[GAIN_W-1:0];
      csr_bus.index <= CSR_GATE_RADIUS;
      csr_bus.data  <= radius_word;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      strobe_half = radius_word[RAD_W-1:0];
      csr_bus.valid <= 1'b0;
      register_loads++;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic directed_cases();
      coord_type lx;
      coord_type ly;
      // reports before any track are dropped
      send_sweep(REQ_REPORT, 1'b1, COORD_TOP, COORD_BOTTOM);
      send_sweep(REQ_REPORT, 1'b0, '0, '1);
      // corner to corner: second point taken as is, prediction saturates
      send_sweep(REQ_START, 1'b1, COORD_TOP, COORD_BOTTOM);
      send_sweep(REQ_REPORT, 1'b1, COORD_BOTTOM, COORD_TOP);
      send_sweep(REQ_REPORT, 1'b0, '0, '0);
      send_sweep(REQ_REPORT, 1'b1, COORD_TOP, COORD_TOP);
      // missing second point repeats the start point
      send_sweep(REQ_START, 1'b0, '1, coord_type'(1));
      send_sweep(REQ_REPORT, 1'b0, coord_type'(5), coord_type'(5));
      send_sweep(REQ_REPORT, 1'b1, coord_type'(-700), coord_type'(900));
      // gate edges: exactly on the radius is outside, one less is inside
      send_sweep(REQ_START, 1'b1, coord_type'(1000), coord_type'(-1000));
      send_sweep(REQ_REPORT, 1'b1, clamp_coord(1000 + longint'(strobe_half)),
                 coord_type'(-1000));
      lx = ring_x[newest_slot()];
      ly = ring_y[newest_slot()];
      send_sweep(REQ_REPORT, 1'b1, clamp_coord(longint'(lx) + strobe_half - 1),
                 clamp_coord(longint'(ly) - strobe_half + 1));
      lx = ring_x[newest_slot()];
      ly = ring_y[newest_slot()];
      send_sweep(REQ_REPORT, 1'b1, lx, clamp_coord(longint'(ly) - strobe_half));
      // steady motion past the window so the ring wraps
      repeat (10)
         send_sweep(REQ_REPORT, 1'b1, clamp_coord(longint'(next_x) + 300),
                    clamp_coord(longint'(next_y) - 200));
   endtask

   // mostly tracks fed near their prediction, with fresh starts and noise mixed in
   task automatic random_tracks(int count);
      int pick;
      logic seen;
      repeat (count) begin
         pick = $urandom_range(99);
         seen = ($urandom_range(99) < 80);
         if (pick < 4) begin
            if ($urandom_range(3) == 0)
               send_sweep(REQ_START, seen, rail_coord(), rail_coord());
            else
               send_sweep(REQ_START, seen, any_coord(), any_coord());
         end else if (pick < 12) begin
            send_sweep(REQ_REPORT, 1'($urandom_range(1)), any_coord(), any_coord());
         end else begin
            send_sweep(REQ_REPORT, seen, near_coord(next_x), near_coord(next_y));
         end
      end
   endtask

   // long run of missing measurements to saturate the miss counter
   task automatic coast_streak();
      send_sweep(REQ_START, 1'b1, any_coord(), any_coord());
      send_sweep(REQ_REPORT, 1'b1, near_coord(next_x), near_coord(next_y));
      repeat (260) send_sweep(REQ_REPORT, 1'b0, any_coord(), any_coord());
      send_sweep(REQ_REPORT, 1'b1, near_coord(next_x), near_coord(next_y));
   endtask

   // hold the response side off while requests keep coming, so the input stalls
   task automatic backpressure_burst();
      hold_left = HOLD_CYCLES;
      repeat (16) send_sweep(REQ_REPORT, ($urandom_range(99) < 70),
                             near_coord(next_x), near_coord(next_y));
   endtask

   // ---------------------------------------------------------------- clock, reset, sequence

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_START;
      req_bus.meas_valid = 1'b0;
      req_bus.meas_x     = '0;
      req_bus.meas_y     = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_BLEND_GAIN;
      csr_bus.data       = '0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      hold_left          = 0;
      items_sent         = 0;
      results_checked    = 0;
      mismatches         = 0;
      gate_hits          = 0;
      rail_hits          = 0;
      coast_peak         = 0;
      register_loads     = 0;
      ring_head          = 0;
      ring_fill          = 0;
      coast_run          = 0;
      next_x             = '0;
      next_y             = '0;
      gain_q16           = GAIN_RESET;
      strobe_half        = RAD_RESET;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_x[i] = '0;
         ring_y[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed_cases();

      // gain of one, widest strobe, no idling
      settle();
      load_registers(23'(GAIN_ONE), 23'h7FFFFF);
      random_tracks(190);

      // zero gain, closed strobe, sender idles
      settle();
      send_idle_pct = 64;
      load_registers('0, '0);
      random_tracks(190);

      // gain above one clamps, narrow strobe, receiver stalls
      settle();
      send_idle_pct = 0;
      stall_pct     = 64;
      load_registers(23'h7FFFFF, 23'd300);
      random_tracks(190);

      // random gain, default strobe, both sides idle
      settle();
      send_idle_pct = 20;
      stall_pct     = 20;
      load_registers(23'($urandom_range(65536)), 23'(RAD_RESET));
      random_tracks(190);
      coast_streak();

      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
      backpressure_burst();

      settle();
      $display("ran %0d requests over %0d register loads; %0d responses checked",
               items_sent, register_loads, results_checked);
      $display("seen: %0d gate hits, %0d saturated predictions, peak miss count %0d",
               gate_hits, rail_hits, coast_peak);
      if (mismatches == 0)
         $display("[track_filter_predictor] OK");
      else
         $display("[track_filter_predictor] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // drive ready: count down a hold-off, else stall at random
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen_result.track_x    = rsp_bus.track_x;
         seen_result.track_y    = rsp_bus.track_y;
         seen_result.pred_x     = rsp_bus.pred_x;
         seen_result.pred_y     = rsp_bus.pred_y;
         seen_result.in_gate    = rsp_bus.in_gate;
         seen_result.miss_count = rsp_bus.miss_count;
         if (pending_tracks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response with no request outstanding: track (%0d,%0d)",
                        seen_result.track_x, seen_result.track_y);
         end else begin
            want_result = pending_tracks.pop_front();
            results_checked++;
            if (want_result.in_gate) gate_hits++;
            if (want_result.pred_x == COORD_TOP || want_result.pred_x == COORD_BOTTOM ||
                want_result.pred_y == COORD_TOP || want_result.pred_y == COORD_BOTTOM)
               rail_hits++;
            if (int'(want_result.miss_count) > coast_peak)
               coast_peak = int'(want_result.miss_count);
            if (seen_result.track_x !== want_result.track_x ||
                seen_result.track_y !== want_result.track_y ||
                seen_result.pred_x !== want_result.pred_x ||
                seen_result.pred_y !== want_result.pred_y ||
                seen_result.in_gate !== want_result.in_gate ||
                seen_result.miss_count !== want_result.miss_count) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"response %0d: expected track (%0d,%0d) pred (%0d,%0d) ",
                            "gate %0b miss %0d; got track (%0d,%0d) pred (%0d,%0d) ",
                            "gate %0b miss %0d"},
                           results_checked,
                           want_result.track_x, want_result.track_y,
                           want_result.pred_x, want_result.pred_y,
                           want_result.in_gate, want_result.miss_count,
                           seen_result.track_x, seen_result.track_y,
                           seen_result.pred_x, seen_result.pred_y,
                           seen_result.in_gate, seen_result.miss_count);
            end
         end
      end
   end

   // end the run if it hangs
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_tracks.size());
         $display("[track_filter_predictor] ERROR");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
rtl/tfp_pkg.sv
rtl/tfp_if.sv
rtl/tfp_div.sv
rtl/track_filter_predictor.sv
tb/sv/track_filter_predictor_tb.sv
